FILE: rtl/core/cssed_pkg.sv
package cssed_pkg;

	localparam logic [7:0] BACKSLASH = 8'h5C;
	localparam logic [7:0] NEWLINE = 8'h0A;
	localparam logic [2:0] MAX_HEX_DIGITS = 3'd6;
	localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

	// The queue depth must be a power of two so that the pointers wrap on their own.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	// Everything one input byte produces: an optional code point, then an
	// optional literal byte, and the end-of-string flags.
	typedef struct packed {
		logic        cp_en;
		logic [20:0] cp;
		logic [1:0]  len_m1;
		logic        chr_en;
		logic [7:0]  chr;
		logic        last;
		logic        changed;
	} desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

FILE: rtl/core/cssed_in_if.sv
interface cssed_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: rtl/core/cssed_out_if.sv
interface cssed_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       out_last;
	logic       changed;

	modport source (output valid, output out_byte, output out_valid, output out_last,
		output changed, input ready);
	modport sink (input valid, input out_byte, input out_valid, input out_last,
		input changed, output ready);
endinterface

FILE: rtl/core/css_escape_decoder_top.sv
// Decodes CSS backslash escapes in a byte stream into UTF-8. The input side takes one byte per
// cycle with no bubbles as long as the four-entry queue between the decoder front and the
// output sequencer has room; the output side delivers one byte per cycle while the receiver is
// ready. A byte that ends a hex escape can expand to as many as five output bytes (a four-byte
// UTF-8 sequence plus the byte itself), so a run of such bytes fills the queue and holds off
// the input until the output sequencer catches up. An input byte is queued, then registered
// at the output. Every string ends with exactly one result flagged last, which also reports
// whether a backslash appeared; a last byte that yields nothing gives an empty end marker.
module css_escape_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	cssed_in_if.sink    text,
	cssed_out_if.source decoded
);
	import cssed_pkg::*;

	desc_t     push_desc, head;
	q_status_t stat;
	logic      push, pop;

	cssed_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.stat   (stat),
		.push   (push),
		.desc   (push_desc)
	);

	cssed_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_desc),
		.pop    (pop),
		.head   (head),
		.stat   (stat)
	);

	cssed_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.stat    (stat),
		.head    (head),
		.pop     (pop),
		.decoded (decoded)
	);

`ifndef SYNTHESIS
	a_marker_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		decoded.valid && !decoded.out_valid |-> decoded.out_last)
		else $error("empty result that does not end the string");

	a_changed_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		decoded.valid && decoded.changed |-> decoded.out_last)
		else $error("changed flag outside the last result");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("queue popped while empty");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full || pop)
		else $error("queue pushed while full");
`endif

endmodule

FILE: rtl/core/cssed_front.sv
module cssed_front (
	input  logic              clk,
	input  logic              arst_n,
	cssed_in_if.sink          text,
	input  cssed_pkg::q_status_t stat,
	output logic              push,
	output cssed_pkg::desc_t  desc
);
	import cssed_pkg::*;

	typedef enum logic [1:0] {PLAIN, ESCAPE, HEX, AFTER_HEX} mode_t;

	mode_t       mode_q, mode_d;
	logic [2:0]  cnt_q, cnt_d, cnt_inc;
	logic [23:0] code_q, code_d, code_ext, cp_raw;
	logic        saw_q, saw_d;
	logic        acc, dv, ws, is_bs, plain, cp_en, chr_en;
	logic [3:0]  dig;
	logic [20:0] cp_ok;
	logic [1:0]  len_m1;

	function automatic logic [20:0] sanitize(logic [23:0] v);
		logic bad;
		bad = (v == 24'd0) || (v >= 24'h00D800 && v <= 24'h00DFFF) || (v > 24'h10FFFF);
		return bad ? REPLACEMENT_CP : v[20:0];
	endfunction

	function automatic logic [1:0] utf8_len_m1(logic [20:0] v);
		logic [1:0] r;
		if (v < 21'h80)
			r = 2'd0;
		else if (v < 21'h800)
			r = 2'd1;
		else if (v < 21'h10000)
			r = 2'd2;
		else
			r = 2'd3;
		return r;
	endfunction

	assign acc = text.valid && text.ready;
	assign text.ready = !stat.full;
	assign is_bs = (text.in_byte == BACKSLASH);
	assign ws = (text.in_byte == 8'h20) || (text.in_byte >= 8'h09 && text.in_byte <= 8'h0D);
	assign cnt_inc = cnt_q + 3'd1;
	assign code_ext = {code_q[19:0], dig};
	assign saw_d = saw_q || is_bs;

	always_comb begin
		dv = 1'b1;
		dig = 4'd0;
		if (text.in_byte >= "0" && text.in_byte <= "9")
			dig = 4'(text.in_byte - 8'h30);
		else if (text.in_byte >= "a" && text.in_byte <= "f")
			dig = 4'(text.in_byte - 8'h57);
		else if (text.in_byte >= "A" && text.in_byte <= "F")
			dig = 4'(text.in_byte - 8'h37);
		else
			dv = 1'b0;
	end

	always_comb begin
		mode_d = mode_q;
		cnt_d = cnt_q;
		code_d = code_q;
		cp_en = 1'b0;
		cp_raw = code_q;
		chr_en = 1'b0;
		plain = 1'b0;
		case (mode_q)
			PLAIN: plain = 1'b1;
			ESCAPE: begin
				if (dv) begin
					mode_d = HEX;
					cnt_d = 3'd1;
					code_d = {20'd0, dig};
				end else begin
					mode_d = PLAIN;
					chr_en = (text.in_byte != NEWLINE);
				end
			end
			HEX: begin
				if (dv) begin
					code_d = code_ext;
					cnt_d = cnt_inc;
					if (cnt_inc >= MAX_HEX_DIGITS) begin
						cp_en = 1'b1;
						cp_raw = code_ext;
						code_d = 24'd0;
						cnt_d = 3'd0;
						mode_d = AFTER_HEX;
					end
				end else begin
					cp_en = 1'b1;
					cp_raw = code_q;
					code_d = 24'd0;
					cnt_d = 3'd0;
					mode_d = PLAIN;
					plain = !ws;
				end
			end
			AFTER_HEX: begin
				mode_d = PLAIN;
				plain = !ws;
			end
			default: mode_d = PLAIN;
		endcase
		if (plain) begin
			if (is_bs)
				mode_d = ESCAPE;
			else
				chr_en = 1'b1;
		end
		// A hex escape still open at the end of the string is flushed here.
		if (text.in_last && mode_d == HEX) begin
			cp_en = 1'b1;
			cp_raw = code_d;
		end
	end

	assign cp_ok = sanitize(cp_raw);
	assign len_m1 = utf8_len_m1(cp_ok);

	assign push = acc && (cp_en || chr_en || text.in_last);
	assign desc.cp_en = cp_en;
	assign desc.cp = cp_ok;
	assign desc.len_m1 = len_m1;
	assign desc.chr_en = chr_en;
	assign desc.chr = text.in_byte;
	assign desc.last = text.in_last;
	assign desc.changed = saw_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= PLAIN;
			cnt_q <= 3'd0;
			code_q <= 24'd0;
			saw_q <= 1'b0;
		end else if (acc) begin
			if (text.in_last) begin
				mode_q <= PLAIN;
				cnt_q <= 3'd0;
				code_q <= 24'd0;
				saw_q <= 1'b0;
			end else begin
				mode_q <= mode_d;
				cnt_q <= cnt_d;
				code_q <= code_d;
				saw_q <= saw_d;
			end
		end
	end

endmodule

FILE: rtl/core/cssed_queue.sv
module cssed_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cssed_pkg::desc_t     wdata,
	input  logic                 pop,
	output cssed_pkg::desc_t     head,
	output cssed_pkg::q_status_t stat
);
	import cssed_pkg::*;

	desc_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q, rd_q;
	logic [QUEUE_AW:0]   level_q;

	assign head = mem_q[rd_q];
	assign stat.full = (level_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign stat.empty = (level_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			level_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QUEUE_AW'(1);
			if (pop)
				rd_q <= rd_q + QUEUE_AW'(1);
			if (push && !pop)
				level_q <= level_q + (QUEUE_AW+1)'(1);
			else if (pop && !push)
				level_q <= level_q - (QUEUE_AW+1)'(1);
		end
	end

endmodule

FILE: rtl/core/cssed_back.sv
module cssed_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cssed_pkg::q_status_t stat,
	input  cssed_pkg::desc_t     head,
	output logic                 pop,
	cssed_out_if.source          decoded
);
	import cssed_pkg::*;

	logic [2:0] idx_q, nitems, nsum;
	logic       vld_q, load, take, fin;
	logic [7:0] byte_d, byte_q;
	logic       ov_d, ov_q, olast_d, olast_q, ochg_q;

	function automatic logic [7:0] utf8_byte(logic [20:0] cp, logic [1:0] len_m1,
		logic [1:0] pos);
		logic [7:0] r;
		logic [1:0] sh;
		sh = len_m1 - pos;
		if (pos == 2'd0) begin
			case (len_m1)
				2'd0: r = {1'b0, cp[6:0]};
				2'd1: r = {3'b110, cp[10:6]};
				2'd2: r = {4'b1110, cp[15:12]};
				default: r = {5'b11110, cp[20:18]};
			endcase
		end else begin
			case (sh)
				2'd0: r = {2'b10, cp[5:0]};
				2'd1: r = {2'b10, cp[11:6]};
				2'd2: r = {2'b10, cp[17:12]};
				default: r = {2'b10, 3'b000, cp[20:18]};
			endcase
		end
		return r;
	endfunction

	// An entry with neither a code point nor a byte is an end marker.
	assign nsum = (head.cp_en ? ({1'b0, head.len_m1} + 3'd1) : 3'd0) + {2'b00, head.chr_en};
	assign nitems = (nsum == 3'd0) ? 3'd1 : nsum;

	assign load = !vld_q || decoded.ready;
	assign take = load && !stat.empty;
	assign fin = (idx_q == nitems - 3'd1);
	assign pop = take && fin;

	always_comb begin
		if (head.cp_en && idx_q <= {1'b0, head.len_m1}) begin
			byte_d = utf8_byte(head.cp, head.len_m1, idx_q[1:0]);
			ov_d = 1'b1;
		end else if (head.chr_en) begin
			byte_d = head.chr;
			ov_d = 1'b1;
		end else begin
			byte_d = 8'd0;
			ov_d = 1'b0;
		end
		olast_d = head.last && fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= 3'd0;
		end else begin
			if (load)
				vld_q <= !stat.empty;
			if (take)
				idx_q <= fin ? 3'd0 : idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q <= byte_d;
			ov_q <= ov_d;
			olast_q <= olast_d;
			ochg_q <= olast_d && head.changed;
		end
	end

	assign decoded.valid = vld_q;
	assign decoded.out_byte = byte_q;
	assign decoded.out_valid = ov_q;
	assign decoded.out_last = olast_q;
	assign decoded.changed = ochg_q;

endmodule

FILE: tb/cssed_checker.sv
module cssed_checker (
	input  logic  clk,
	input  logic  arst_n,
	cssed_in_if   text,
	cssed_out_if  decoded,
	output int    errors,
	output int    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import cssed_pkg::*;

	typedef enum logic [1:0] {
		IN_TEXT,
		AFTER_BSLASH,
		IN_HEX,
		AFTER_SIX
	} dec_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic       data_ok;
		logic       last;
		logic       changed;
	} utf8_beat_t;

	dec_state_t  st = IN_TEXT;
	logic [2:0]  ndig = '0;
	logic [23:0] acc = '0;
	logic        seen_bs = 1'b0;
	int          beats_now;
	utf8_beat_t  expected_utf8[$];
	int          fail_count = 0;
	int          pending = 0;

	assign errors = fail_count;
	assign outstanding = pending;

	function automatic int hex_digit(logic [7:0] b);
		if (b >= "0" && b <= "9") return int'(b - "0");
		if (b >= "a" && b <= "f") return int'(b - "a") + 10;
		if (b >= "A" && b <= "F") return int'(b - "A") + 10;
		return -1;
	endfunction

	function automatic logic is_space(logic [7:0] b);
		return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic void emit(logic [7:0] b, logic ok);
		utf8_beat_t beat;
		beat.data = b;
		beat.data_ok = ok;
		beat.last = 1'b0;
		beat.changed = 1'b0;
		expected_utf8.push_back(beat);
		beats_now++;
	endfunction

	// Zero, surrogates and anything past the last plane fold to the replacement character.
	function automatic void emit_code(logic [23:0] v);
		logic [20:0] c;
		if (v == 0 || (v >= 24'hD800 && v <= 24'hDFFF) || v > 24'h10FFFF)
			c = REPLACEMENT_CP;
		else
			c = v[20:0];
		if (c < 21'h80) begin
			emit(c[7:0], 1'b1);
		end else if (c < 21'h800) begin
			emit(8'hC0 | 8'(c >> 6), 1'b1);
			emit(8'h80 | 8'(c[5:0]), 1'b1);
		end else if (c < 21'h10000) begin
			emit(8'hE0 | 8'(c >> 12), 1'b1);
			emit(8'h80 | 8'(c[11:6]), 1'b1);
			emit(8'h80 | 8'(c[5:0]), 1'b1);
		end else begin
			emit(8'hF0 | 8'(c >> 18), 1'b1);
			emit(8'h80 | 8'(c[17:12]), 1'b1);
			emit(8'h80 | 8'(c[11:6]), 1'b1);
			emit(8'h80 | 8'(c[5:0]), 1'b1);
		end
	endfunction

	function automatic void flush_code();
		emit_code(acc);
		acc = '0;
		ndig = '0;
	endfunction

	function automatic void take_plain(logic [7:0] b);
		if (b == BACKSLASH)
			st = AFTER_BSLASH;
		else
			emit(b, 1'b1);
	endfunction

	function automatic void clear_decoder();
		st = IN_TEXT;
		ndig = '0;
		acc = '0;
		seen_bs = 1'b0;
	endfunction

	function automatic void decode_byte(logic [7:0] b, logic lst);
		int d;
		d = hex_digit(b);
		beats_now = 0;
		if (b == BACKSLASH)
			seen_bs = 1'b1;
		case (st)
			IN_TEXT: begin
				take_plain(b);
			end
			AFTER_BSLASH: begin
				if (d >= 0) begin
					st = IN_HEX;
					ndig = 3'd1;
					acc = 24'(d);
				end else begin
					st = IN_TEXT;
					if (b != NEWLINE)
						emit(b, 1'b1);
				end
			end
			IN_HEX: begin
				if (d >= 0) begin
					acc = {acc[19:0], d[3:0]};
					ndig = ndig + 3'd1;
					if (ndig >= MAX_HEX_DIGITS) begin
						flush_code();
						st = AFTER_SIX;
					end
				end else begin
					flush_code();
					st = IN_TEXT;
					if (!is_space(b))
						take_plain(b);
				end
			end
			default: begin
				st = IN_TEXT;
				if (!is_space(b))
					take_plain(b);
			end
		endcase
		if (lst) begin
			if (st == IN_HEX)
				flush_code();
			if (beats_now == 0)
				emit(8'h00, 1'b0);
			expected_utf8[expected_utf8.size() - 1].last = 1'b1;
			expected_utf8[expected_utf8.size() - 1].changed = seen_bs;
			clear_decoder();
		end
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		utf8_beat_t want;
		if (!arst_n) begin
			clear_decoder();
			expected_utf8.delete();
		end else begin
			// Check the output transfer before predicting this edge's input; the block
			// cannot answer an input in the cycle it takes it.
			if (decoded.valid && decoded.ready) begin
				if (expected_utf8.size() == 0) begin
					$display("%0t: expected nothing, got %02h valid %b last %b changed %b",
						$time, decoded.out_byte, decoded.out_valid, decoded.out_last,
						decoded.changed);
					fail_count++;
				end else begin
					want = expected_utf8.pop_front();
					check_field("out_byte", want.data, decoded.out_byte);
					check_field("out_valid", want.data_ok, decoded.out_valid);
					check_field("out_last", want.last, decoded.out_last);
					check_field("changed", want.changed, decoded.changed);
				end
			end
			if (text.valid && text.ready)
				decode_byte(text.in_byte, text.in_last);
		end
		pending = expected_utf8.size();
	end

endmodule

FILE: tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cssed_pkg::*;

	localparam int ITEMS_PER_PHASE = 100;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors;
	int   outstanding;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   quiet_cycles = 0;
	int   sent_count = 0;
	logic [7:0] text_bytes[$];

	int idle_by_phase[4] = '{0, 50, 0, 16};
	int stall_by_phase[4] = '{0, 0, 50, 16};

	cssed_in_if  text_if();
	cssed_out_if utf8_if();

	css_escape_decoder_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text_if),
		.decoded (utf8_if)
	);

	cssed_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.text        (text_if),
		.decoded     (utf8_if),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		utf8_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Nothing moving on either channel for too long means the block is stuck.
	always @(posedge clk) begin
		if ((text_if.valid && text_if.ready) || (utf8_if.valid && utf8_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [7:0] hex_char(logic [3:0] d, logic upper);
		if (d < 4'd10)
			return 8'("0") + 8'(d);
		return (upper ? 8'("A") : 8'("a")) + 8'(d) - 8'd10;
	endfunction

	function automatic logic [7:0] pick_space();
		logic [7:0] ws[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
		return ws[$urandom_range(5)];
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			text_bytes.push_back(s[i]);
	endfunction

	function automatic void add_hex_escape();
		logic [23:0] v;
		int nd;
		if ($urandom_range(3) == 0) begin
			nd = $urandom_range(1, 6);
			v = 24'($urandom);
		end else begin
			// Aim at the code point classes, written out as six digits.
			nd = 6;
			case ($urandom_range(7))
				0: v = 24'h0;
				1: v = 24'hD800 + 24'($urandom_range(24'h7FF));
				2: v = 24'h110000 + 24'($urandom_range(24'hEFFFFF));
				3: v = 24'h10FFFF;
				4: v = 24'($urandom_range(24'h7F));
				5: v = 24'($urandom_range(24'h80, 24'h7FF));
				6: v = 24'($urandom_range(24'h800, 24'hFFFF));
				default: v = 24'($urandom_range(24'h10000, 24'h10FFFF));
			endcase
		end
		text_bytes.push_back(BACKSLASH);
		for (int i = nd - 1; i >= 0; i--)
			text_bytes.push_back(hex_char(v[i*4 +: 4], 1'($urandom_range(1))));
		case ($urandom_range(3))
			1: text_bytes.push_back(pick_space());
			2: text_bytes.push_back(8'($urandom_range(255)));
			default: ;
		endcase
	endfunction

	function automatic void add_random_string();
		int pieces;
		pieces = $urandom_range(1, 5);
		repeat (pieces) begin
			case ($urandom_range(9))
				0, 1, 2: text_bytes.push_back(8'($urandom_range(255)));
				7: begin
					text_bytes.push_back(BACKSLASH);
					text_bytes.push_back(NEWLINE);
				end
				8: begin
					text_bytes.push_back(BACKSLASH);
					text_bytes.push_back(8'($urandom_range(255)));
				end
				9: begin
					text_bytes.push_back(BACKSLASH);
					text_bytes.push_back(BACKSLASH);
				end
				default: add_hex_escape();
			endcase
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_byte(logic [7:0] b, logic lst);
		while ($urandom_range(99) < idle_pct) begin
			text_if.valid <= 1'b0;
			@(negedge clk);
		end
		text_if.valid <= 1'b1;
		text_if.in_byte <= b;
		text_if.in_last <= lst;
		@(posedge clk);
		while (!text_if.ready)
			@(posedge clk);
		@(negedge clk);
		sent_count++;
	endtask

	task automatic send_string();
		logic [7:0] b;
		while (text_bytes.size() != 0) begin
			b = text_bytes.pop_front();
			send_byte(b, text_bytes.size() == 0);
		end
	endtask

	initial begin
		int phase_start;
		text_if.valid = 1'b0;
		text_if.in_byte = 8'h00;
		text_if.in_last = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Field extremes, an escaped letter and an escaped backslash.
		text_bytes.push_back(8'hFF);
		push_text("\\q\\\\");
		text_bytes.push_back(8'h00);
		send_string();
		// Short escape closed by whitespace, then a surrogate flushed by the end of string.
		push_text("\\41 b\\D800");
		send_string();
		// Five-digit escape to four UTF-8 bytes; the trailing space ends it and the string.
		push_text("\\1F600 ");
		send_string();
		push_text("\\\n");
		send_string();
		push_text("\\");
		send_string();

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = idle_by_phase[ph];
			stall_pct = stall_by_phase[ph];
			phase_start = sent_count;
			while (sent_count - phase_start < ITEMS_PER_PHASE) begin
				add_random_string();
				send_string();
			end
		end
		text_if.valid <= 1'b0;

		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
